// ----- hdl/rgbab_pkg.sv -----
`default_nettype none

package rgbab_pkg;

    localparam int FRAC_BITS = 8;
    localparam int AMT_W     = FRAC_BITS + 1;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;
    localparam int SQ_W      = 2 * CH_W;
    localparam int PROD_W    = SQ_W + FRAC_BITS;
    localparam int REM_W     = CH_W + 2;
    localparam int SQRT_STAGES     = 4;
    localparam int STEPS_PER_STAGE = CH_W / SQRT_STAGES;

    localparam logic [AMT_W-1:0] AMOUNT_ONE = AMT_W'(1 << FRAC_BITS);

    typedef logic [1:0] opcode_t;
    localparam opcode_t OP_MULTIPLY = 2'd0;
    localparam opcode_t OP_LERP     = 2'd1;
    localparam opcode_t OP_GAMMA    = 2'd2;

    typedef logic [NUM_CH-1:0][CH_W-1:0]   chan_vec_t;
    typedef logic [NUM_CH-1:0][SQ_W-1:0]   sq_vec_t;
    typedef logic [NUM_CH-1:0][PROD_W-1:0] prod_vec_t;

    // input register: operands with the amount already clamped to one
    typedef struct packed {
        logic             valid;
        opcode_t          op;
        chan_vec_t        a;
        chan_vec_t        b;
        logic [AMT_W-1:0] t;
    } stage_in_t;

    // squared (or plain) operands and the raw multiply product
    typedef struct packed {
        logic             valid;
        opcode_t          op;
        sq_vec_t          x;
        sq_vec_t          y;
        sq_vec_t          ab;
        logic [AMT_W-1:0] t;
    } stage_sq_t;

    // weighted terms
    typedef struct packed {
        logic      valid;
        opcode_t   op;
        prod_vec_t m0;
        prod_vec_t m1;
        sq_vec_t   ab;
    } stage_wt_t;

    // one square root lane state
    typedef struct packed {
        logic [SQ_W-1:0]  rad;
        logic [REM_W-1:0] rem;
        logic [CH_W-1:0]  root;
    } sqrt_lane_t;

    typedef struct packed {
        logic                        valid;
        opcode_t                     op;
        chan_vec_t                   plain;
        logic [NUM_CH-1:0][SQ_W+REM_W+CH_W-1:0] lane;
    } stage_rt_t;

    // one digit of a restoring square root
    function automatic sqrt_lane_t sqrt_step(input sqrt_lane_t s);
        logic [REM_W+1:0] r4;
        logic [REM_W+1:0] trial;
        sqrt_lane_t       n;
        r4    = {s.rem, s.rad[SQ_W-1 -: 2]};
        trial = (REM_W+2)'({s.root, 2'b01});
        n.rad = {s.rad[SQ_W-3:0], 2'b00};
        if (r4 >= trial)
        begin
            n.rem  = REM_W'(r4 - trial);
            n.root = {s.root[CH_W-2:0], 1'b1};
        end
        else
        begin
            n.rem  = REM_W'(r4);
            n.root = {s.root[CH_W-2:0], 1'b0};
        end
        return n;
    endfunction

    // floor(p / 255) for p up to 255*255
    function automatic logic [CH_W-1:0] div255(input logic [SQ_W-1:0] p);
        logic [SQ_W:0] s;
        s = {1'b0, p} + (SQ_W+1)'(p >> CH_W) + (SQ_W+1)'(1);
        return s[SQ_W-1:CH_W];
    endfunction

endpackage

`default_nettype wire

// ----- hdl/rgba_blend_unit.sv -----
`default_nettype none

// rgba blend unit: combines two 8-bit rgba colors channel by channel.
// opcode multiply gives floor(a*b/255), linear blend gives the floor of
// a*(1-t) + b*t, gamma-2 blend gives the floor of the square root of
// a*a*(1-t) + b*b*t, and the unused opcode gives all zeros. blend_amount is
// unsigned q1.8; anything above 256 acts as 256 (fully the second color).
// a beat is taken at every clock edge where start is high; busy is always
// low, so one pixel per clock is sustained with no gaps. every beat's result
// shows up on the out_* ports, marked by a one-cycle done pulse; results
// leave in the same order. the receiver cannot stall: it must capture the
// result in the cycle that done is high. the pipeline registers are: input
// register, squaring multipliers, weighting multipliers, sum and divide-by-255
// reciprocal, four square root stages of two root bits each, and the output
// register.

module rgba_blend_unit
    import rgbab_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           opcode,
    input  wire logic [CH_W-1:0]      first_red,
    input  wire logic [CH_W-1:0]      first_green,
    input  wire logic [CH_W-1:0]      first_blue,
    input  wire logic [CH_W-1:0]      first_alpha,
    input  wire logic [CH_W-1:0]      second_red,
    input  wire logic [CH_W-1:0]      second_green,
    input  wire logic [CH_W-1:0]      second_blue,
    input  wire logic [CH_W-1:0]      second_alpha,
    input  wire logic [AMT_W-1:0]     blend_amount,
    output logic                      done,
    output logic [CH_W-1:0]           out_red,
    output logic [CH_W-1:0]           out_green,
    output logic [CH_W-1:0]           out_blue,
    output logic [CH_W-1:0]           out_alpha
);

    stage_in_t  s1_reg, s1_next;
    stage_sq_t  s2_reg, s2_next;
    stage_wt_t  s3_reg, s3_next;
    stage_rt_t  s4_next;
    stage_rt_t  rt_reg  [SQRT_STAGES+1];
    stage_rt_t  rt_next [SQRT_STAGES+1];
    logic       done_reg, done_next;
    chan_vec_t  out_reg, out_next;

    // the pipeline never stalls, so a new beat is always welcome
    assign busy = 1'b0;

    // stage 1: capture the beat and clamp the amount to one
    always_comb
    begin
        s1_next.valid = start;
        s1_next.op    = opcode_t'(opcode);
        s1_next.a     = {first_alpha, first_blue, first_green, first_red};
        s1_next.b     = {second_alpha, second_blue, second_green, second_red};
        s1_next.t     = (blend_amount > AMOUNT_ONE) ? AMOUNT_ONE : blend_amount;
    end

    // stage 2: square the channels for gamma mode, plus the multiply product
    always_comb
    begin
        s2_next.valid = s1_reg.valid;
        s2_next.op    = s1_reg.op;
        s2_next.t     = s1_reg.t;
        for (int c = 0; c < NUM_CH; c++)
        begin
            s2_next.ab[c] = SQ_W'(s1_reg.a[c]) * SQ_W'(s1_reg.b[c]);
            if (s1_reg.op == OP_GAMMA)
            begin
                s2_next.x[c] = SQ_W'(s1_reg.a[c]) * SQ_W'(s1_reg.a[c]);
                s2_next.y[c] = SQ_W'(s1_reg.b[c]) * SQ_W'(s1_reg.b[c]);
            end
            else
            begin
                s2_next.x[c] = SQ_W'(s1_reg.a[c]);
                s2_next.y[c] = SQ_W'(s1_reg.b[c]);
            end
        end
    end

    // stage 3: weight both operands; the weights always sum to one
    always_comb
    begin
        s3_next.valid = s2_reg.valid;
        s3_next.op    = s2_reg.op;
        s3_next.ab    = s2_reg.ab;
        for (int c = 0; c < NUM_CH; c++)
        begin
            s3_next.m0[c] = PROD_W'(PROD_W'(s2_reg.x[c]) * PROD_W'(AMOUNT_ONE - s2_reg.t));
            s3_next.m1[c] = PROD_W'(PROD_W'(s2_reg.y[c]) * PROD_W'(s2_reg.t));
        end
    end

    // stage 4: sum and drop the fraction, or divide the product by 255;
    // the result also seeds the square root lanes
    always_comb
    begin
        logic [PROD_W-1:0] sum;
        sqrt_lane_t        seed;
        s4_next.valid = s3_reg.valid;
        s4_next.op    = s3_reg.op;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum = s3_reg.m0[c] + s3_reg.m1[c];
            if (s3_reg.op == OP_MULTIPLY)
            begin
                seed.rad = SQ_W'(div255(s3_reg.ab[c]));
            end
            else
            begin
                seed.rad = sum[PROD_W-1:FRAC_BITS];
            end
            seed.rem          = '0;
            seed.root         = '0;
            s4_next.plain[c]  = seed.rad[CH_W-1:0];
            s4_next.lane[c]   = seed;
        end
    end

    // square root stages: two root bits per stage
    always_comb
    begin
        sqrt_lane_t ln;
        rt_next[0] = s4_next;
        for (int s = 1; s <= SQRT_STAGES; s++)
        begin
            rt_next[s] = rt_reg[s-1];
            for (int c = 0; c < NUM_CH; c++)
            begin
                ln = rt_reg[s-1].lane[c];
                for (int k = 0; k < STEPS_PER_STAGE; k++)
                begin
                    ln = sqrt_step(ln);
                end
                rt_next[s].lane[c] = ln;
            end
        end
    end

    // output select: plain result for multiply and linear blend, root for gamma mode, zero for the unused opcode
    always_comb
    begin
        sqrt_lane_t ln;
        done_next = rt_reg[SQRT_STAGES].valid;
        for (int c = 0; c < NUM_CH; c++)
        begin
            ln = rt_reg[SQRT_STAGES].lane[c];
            case (rt_reg[SQRT_STAGES].op) inside
                OP_MULTIPLY, OP_LERP: out_next[c] = rt_reg[SQRT_STAGES].plain[c];
                OP_GAMMA:             out_next[c] = ln.root;
                default:              out_next[c] = '0;
            endcase
        end
    end

    // pipeline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            s3_reg <= '0;
            for (int s = 0; s <= SQRT_STAGES; s++)
            begin
                rt_reg[s] <= '0;
            end
            done_reg <= 1'b0;
            out_reg  <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            for (int s = 0; s <= SQRT_STAGES; s++)
            begin
                rt_reg[s] <= rt_next[s];
            end
            done_reg <= done_next;
            out_reg  <= out_next;
        end
    end

    assign done      = done_reg;
    assign out_red   = out_reg[0];
    assign out_green = out_reg[1];
    assign out_blue  = out_reg[2];
    assign out_alpha = out_reg[3];

    // every taken beat comes back as a done pulse
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##9 done)
        else $error("beat lost in pipeline");

    // no result without a beat entering the pipeline
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(s1_reg.valid, 8))
        else $error("result without a matching beat");

    // the unused opcode gives black transparent
    a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rt_reg[SQRT_STAGES].valid && rt_reg[SQRT_STAGES].op != OP_MULTIPLY
         && rt_reg[SQRT_STAGES].op != OP_LERP && rt_reg[SQRT_STAGES].op != OP_GAMMA)
        |=> (out_reg == '0))
        else $error("unused opcode gave nonzero result");

    // the clamped amount never exceeds one
    a_amount_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        s1_reg.valid |-> (s1_reg.t <= AMOUNT_ONE))
        else $error("amount not clamped");

endmodule

`default_nettype wire
